### rtl/mtpc_pkg.sv
// Shared types, constants and field widths of the memory test pattern checker.
`default_nettype none

package mtpc_pkg;

    // Default sizing of the sequencer counters.
    localparam int MAX_WORDS_DEF  = 1048576;
    localparam int MAX_PASSES_DEF = 4096;

    // Configuration register file.
    localparam int WORD_COUNT_W  = 21;
    localparam int PASS_COUNT_W  = 13;
    localparam int CFG_DATA_W    = 21;
    localparam int CFG_INDEX_W   = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_WORD_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PASS_COUNT = 1'd1;
    localparam int WORD_COUNT_RESET = 32768;
    localparam int PASS_COUNT_RESET = 128;

    // Payload field widths.
    localparam int DATA_W     = 64;
    localparam int INDEX_W    = 20;
    localparam int PASS_NUM_W = 12;
    localparam int STATUS_W   = 3;

    // Multiplier of the address scramble term (index times this, mod 2^64).
    localparam logic [DATA_W-1:0] GOLDEN_MUL = 64'h9e37_79b9_7f4a_7c15;

    typedef enum logic [STATUS_W-1:0] {
        ST_STARTED     = 3'd0,
        ST_WRITE       = 3'd1,
        ST_MATCH       = 3'd2,
        ST_MISMATCH    = 3'd3,
        ST_ALL_PASSED  = 3'd4,
        ST_NOT_RUNNING = 3'd5
    } status_t;

    typedef struct packed {
        status_t                 status;
        logic [INDEX_W-1:0]      word_index;
        logic [PASS_NUM_W-1:0]   pass_number;
        logic [DATA_W-1:0]       pattern_word;
    } result_t;

    // Background pattern chosen by the low two bits of the pass number.
    function automatic logic [DATA_W-1:0] base_pattern(input logic [1:0] sel);
        logic [DATA_W-1:0] pat;
        unique case (sel)
            2'd0: pat = 64'h0000_0000_0000_0000;
            2'd1: pat = 64'hffff_ffff_ffff_ffff;
            2'd2: pat = 64'h5555_5555_5555_5555;
            2'd3: pat = 64'haaaa_aaaa_aaaa_aaaa;
            default: pat = '0;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

### rtl/memory_test_pattern_checker_top.sv
// Top level of the memory test pattern checker.
`default_nettype none

// Write-then-verify memory self-test sequencer. A transfer with s_tuser low starts
// a test; each transfer with s_tuser high steps a running test and yields exactly
// one result: a write request (index and pattern) in the write phase, a compare of
// s_tdata against the expected word in the verify phase, or a not-running status.
// One transfer per clock is taken while the output register is free; its result is
// in that register on the next cycle. The state update sets the rate and keeps the
// index-times-constant scramble term as a running 64-bit sum. The user must write
// counts through the cfg port while no transfer is in flight; it is not enforced.
module memory_test_pattern_checker_top #(
    parameter int MAX_WORDS  = mtpc_pkg::MAX_WORDS_DEF,
    parameter int MAX_PASSES = mtpc_pkg::MAX_PASSES_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [63:0]                         s_tdata,  // read_data
    input  wire logic [0:0]                          s_tuser,  // op
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // word_index [19:0], pass_number [31:20], pattern_word [95:32]
    output logic      [95:0]                         m_tdata,
    output logic      [2:0]                          m_tuser,  // status
    input  wire logic                                cfg_wr_en,
    input  wire logic [mtpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [mtpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [$clog2(MAX_WORDS + 1)-1:0]  eff_words;
    logic [$clog2(MAX_PASSES + 1)-1:0] eff_passes;
    logic                              step_en;
    logic                              slot_free;
    mtpc_pkg::result_t                 step_res;
    mtpc_pkg::result_t                 out_res;

    assign s_tready = slot_free;
    assign step_en  = s_tvalid && slot_free;

    mtpc_cfg #(
        .MAX_WORDS  (MAX_WORDS),
        .MAX_PASSES (MAX_PASSES)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .eff_words  (eff_words),
        .eff_passes (eff_passes)
    );

    mtpc_engine #(
        .MAX_WORDS  (MAX_WORDS),
        .MAX_PASSES (MAX_PASSES)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (step_en),
        .op         (s_tuser[0]),
        .read_data  (s_tdata),
        .eff_words  (eff_words),
        .eff_passes (eff_passes),
        .result     (step_res)
    );

    mtpc_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (step_en),
        .take    (m_tready),
        .res_in  (step_res),
        .ready   (slot_free),
        .valid   (m_tvalid),
        .res_out (out_res)
    );

    assign m_tuser = 3'(out_res.status);
    assign m_tdata = {out_res.pattern_word, out_res.pass_number, out_res.word_index};

endmodule

`default_nettype wire

### rtl/mtpc_cfg.sv
// Configuration registers, kept as effective (clamped) word and pass limits.
`default_nettype none

module mtpc_cfg #(
    parameter int MAX_WORDS  = mtpc_pkg::MAX_WORDS_DEF,
    parameter int MAX_PASSES = mtpc_pkg::MAX_PASSES_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [mtpc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [mtpc_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic      [$clog2(MAX_WORDS + 1)-1:0]       eff_words,
    output logic      [$clog2(MAX_PASSES + 1)-1:0]      eff_passes
);

    localparam int WCNT_W = $clog2(MAX_WORDS + 1);
    localparam int PCNT_W = $clog2(MAX_PASSES + 1);

    // A zero count acts as one; a count above the maximum saturates.
    function automatic logic [31:0] eff_limit(input logic [31:0] v, input logic [31:0] maxv);
        logic [31:0] r;
        if (v == 32'd0) begin
            r = 32'd1;
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

    localparam logic [WCNT_W-1:0] WORDS_RESET =
        WCNT_W'(eff_limit(32'(mtpc_pkg::WORD_COUNT_RESET), 32'(MAX_WORDS)));
    localparam logic [PCNT_W-1:0] PASSES_RESET =
        PCNT_W'(eff_limit(32'(mtpc_pkg::PASS_COUNT_RESET), 32'(MAX_PASSES)));

    logic [WCNT_W-1:0] words_reg, words_next;
    logic [PCNT_W-1:0] passes_reg, passes_next;

    always_comb begin
        words_next  = words_reg;
        passes_next = passes_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                mtpc_pkg::REG_WORD_COUNT: begin
                    words_next = WCNT_W'(eff_limit(
                        32'(cfg_data[mtpc_pkg::WORD_COUNT_W-1:0]), 32'(MAX_WORDS)));
                end
                mtpc_pkg::REG_PASS_COUNT: begin
                    passes_next = PCNT_W'(eff_limit(
                        32'(cfg_data[mtpc_pkg::PASS_COUNT_W-1:0]), 32'(MAX_PASSES)));
                end
                default: begin
                    words_next  = words_reg;
                    passes_next = passes_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            words_reg  <= WORDS_RESET;
            passes_reg <= PASSES_RESET;
        end else begin
            words_reg  <= words_next;
            passes_reg <= passes_next;
        end
    end

    assign eff_words  = words_reg;
    assign eff_passes = passes_reg;

endmodule

`default_nettype wire

### rtl/mtpc_engine.sv
// Test sequencer state and the per-step result logic.
`default_nettype none

module mtpc_engine #(
    parameter int MAX_WORDS  = mtpc_pkg::MAX_WORDS_DEF,
    parameter int MAX_PASSES = mtpc_pkg::MAX_PASSES_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                step_en,
    input  wire logic                                op,
    input  wire logic [mtpc_pkg::DATA_W-1:0]         read_data,
    input  wire logic [$clog2(MAX_WORDS + 1)-1:0]    eff_words,
    input  wire logic [$clog2(MAX_PASSES + 1)-1:0]   eff_passes,
    output mtpc_pkg::result_t                        result
);

    localparam int WCNT_W = $clog2(MAX_WORDS + 1);
    localparam int PCNT_W = $clog2(MAX_PASSES + 1);
    localparam int WIDX_W = $clog2(MAX_WORDS);
    localparam int PIDX_W = (MAX_PASSES > 1) ? $clog2(MAX_PASSES) : 1;

    logic [WIDX_W-1:0]             word_reg, word_next;
    logic [PIDX_W-1:0]             pass_reg, pass_next;
    logic                          verify_reg, verify_next;
    logic                          running_reg, running_next;
    // Running sum of word index times the scramble multiplier.
    logic [mtpc_pkg::DATA_W-1:0]   acc_reg, acc_next;

    logic [mtpc_pkg::DATA_W-1:0]   expected;
    logic                          last_word;
    logic                          last_pass;

    assign expected  = mtpc_pkg::base_pattern(2'(pass_reg)) ^ acc_reg;
    assign last_word = ((WCNT_W + 1)'(word_reg) + (WCNT_W + 1)'(1))
                       >= (WCNT_W + 1)'(eff_words);
    assign last_pass = ((PCNT_W + 1)'(pass_reg) + (PCNT_W + 1)'(1))
                       >= (PCNT_W + 1)'(eff_passes);

    always_comb begin
        word_next    = word_reg;
        pass_next    = pass_reg;
        verify_next  = verify_reg;
        running_next = running_reg;
        acc_next     = acc_reg;

        result              = '0;
        result.status       = mtpc_pkg::ST_NOT_RUNNING;
        result.word_index   = mtpc_pkg::INDEX_W'(word_reg);
        result.pass_number  = mtpc_pkg::PASS_NUM_W'(pass_reg);
        result.pattern_word = expected;

        priority if (!op) begin
            word_next           = '0;
            pass_next           = '0;
            verify_next         = 1'b0;
            running_next        = 1'b1;
            acc_next            = '0;
            result              = '0;
            result.status       = mtpc_pkg::ST_STARTED;
        end else if (!running_reg) begin
            result              = '0;
            result.status       = mtpc_pkg::ST_NOT_RUNNING;
        end else if (!verify_reg) begin
            result.status = mtpc_pkg::ST_WRITE;
            if (last_word) begin
                word_next   = '0;
                acc_next    = '0;
                verify_next = 1'b1;
            end else begin
                word_next = word_reg + WIDX_W'(1);
                acc_next  = acc_reg + mtpc_pkg::GOLDEN_MUL;
            end
        end else if (read_data != expected) begin
            result.status = mtpc_pkg::ST_MISMATCH;
            running_next  = 1'b0;
        end else if (!last_word) begin
            result.status = mtpc_pkg::ST_MATCH;
            word_next     = word_reg + WIDX_W'(1);
            acc_next      = acc_reg + mtpc_pkg::GOLDEN_MUL;
        end else begin
            word_next   = '0;
            acc_next    = '0;
            verify_next = 1'b0;
            if (last_pass) begin
                result.status = mtpc_pkg::ST_ALL_PASSED;
                running_next  = 1'b0;
            end else begin
                result.status = mtpc_pkg::ST_MATCH;
                pass_next     = pass_reg + PIDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg    <= '0;
            pass_reg    <= '0;
            verify_reg  <= 1'b0;
            running_reg <= 1'b0;
            acc_reg     <= '0;
        end else if (step_en) begin
            word_reg    <= word_next;
            pass_reg    <= pass_next;
            verify_reg  <= verify_next;
            running_reg <= running_next;
            acc_reg     <= acc_next;
        end
    end

    // The running sum must always equal the word index times the multiplier.
    a_acc_tracks_index: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_reg == (mtpc_pkg::DATA_W'(word_reg) * mtpc_pkg::GOLDEN_MUL))
        else $error("scramble sum out of step with word index");

    // A start clears the counters and enters the write phase.
    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && !op) |=> (running_reg && !verify_reg && word_reg == '0 && pass_reg == '0))
        else $error("start did not reset the sequencer");

    // A step while stopped leaves the sequencer untouched.
    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && op && !running_reg) |=>
            ($stable(word_reg) && $stable(pass_reg) && $stable(verify_reg) && !running_reg))
        else $error("stopped sequencer changed state");

    // The pass counter never leaves the sized range.
    a_pass_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(pass_reg) < 32'(MAX_PASSES))
        else $error("pass counter beyond maximum");

endmodule

`default_nettype wire

### rtl/mtpc_out_reg.sv
// Result register that decouples the result channel from the step logic.
`default_nettype none

module mtpc_out_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire logic              take,
    input  wire mtpc_pkg::result_t res_in,
    output logic                   ready,
    output logic                   valid,
    output mtpc_pkg::result_t      res_out
);

    logic              valid_reg, valid_next;
    mtpc_pkg::result_t res_reg;

    // A new result can be loaded when the register is empty or drains this cycle.
    assign ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign valid   = valid_reg;
    assign res_out = res_reg;

endmodule

`default_nettype wire
